// ===== src/ggbs_pkg.sv =====
// Package with types, constants and the arctangent table of the go-to-goal steering block.
package ggbs_pkg;

  localparam int VW = 37;
  localparam int ZW = 28;

  localparam logic signed [ZW-1:0] PI_Q24 = 28'sd52707179;
  localparam logic signed [16:0] PI_Q13 = 17'sd25736;
  localparam logic signed [16:0] TWO_PI_Q13 = 17'sd51472;

  localparam logic [30:0] DIST_DB_RST = 31'd6554;
  localparam logic [14:0] ANG_DB_RST = 15'd1638;
  localparam logic [14:0] FWD_SPEED_RST = 15'd128;
  localparam logic [14:0] TURN_SPEED_RST = 15'd128;

  typedef enum logic [1:0] {
    ACT_ARRIVED = 2'd0,
    ACT_LEFT    = 2'd1,
    ACT_RIGHT   = 2'd2,
    ACT_FORWARD = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    CFG_GOAL_X     = 3'd0,
    CFG_GOAL_Y     = 3'd1,
    CFG_DIST_DB    = 3'd2,
    CFG_ANG_DB     = 3'd3,
    CFG_FWD_SPEED  = 3'd4,
    CFG_TURN_SPEED = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic signed [31:0] pose_x;
    logic signed [31:0] pose_y;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
    logic signed [15:0] quat_w;
  } pose_req_t;

  typedef struct packed {
    logic [14:0]        linear_cmd;
    logic signed [15:0] angular_cmd;
    action_e            action;
    logic signed [15:0] steer_err;
  } steer_rsp_t;

  typedef struct packed {
    logic signed [VW-1:0] x;
    logic signed [VW-1:0] y;
    logic signed [ZW-1:0] z;
    logic                 zero;
  } cordic_t;

  function automatic logic signed [ZW-1:0] atan_q24(input int i);
    logic signed [ZW-1:0] r;
    case (i)
      0: r = 28'sd13176795;
      1: r = 28'sd7778716;
      2: r = 28'sd4110060;
      3: r = 28'sd2086331;
      4: r = 28'sd1047214;
      5: r = 28'sd524117;
      6: r = 28'sd262123;
      7: r = 28'sd131069;
      8: r = 28'sd65536;
      9: r = 28'sd32768;
      10: r = 28'sd16384;
      11: r = 28'sd8192;
      12: r = 28'sd4096;
      13: r = 28'sd2048;
      14: r = 28'sd1024;
      15: r = 28'sd512;
      16: r = 28'sd256;
      17: r = 28'sd128;
      18: r = 28'sd64;
      19: r = 28'sd32;
      20: r = 28'sd16;
      21: r = 28'sd8;
      22: r = 28'sd4;
      23: r = 28'sd2;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// ===== src/ggbs_cordic_cell.sv =====
// One vectoring CORDIC iteration cell with its pipeline register.
module ggbs_cordic_cell import ggbs_pkg::*; #(
  parameter int ITER = 0,
  parameter int SW = 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  cordic_t       vec_i,
  input  logic [SW-1:0] side_i,
  output cordic_t       vec_o,
  output logic [SW-1:0] side_o
);

  cordic_t vec_d, vec_q;
  logic [SW-1:0] side_q;
  logic signed [VW-1:0] xs, ys;

  always_comb begin
    xs = vec_i.x >>> ITER;
    ys = vec_i.y >>> ITER;
    vec_d = vec_i;
    if (vec_i.y[VW-1]) begin
      vec_d.x = vec_i.x - ys;
      vec_d.y = vec_i.y + xs;
      vec_d.z = vec_i.z - atan_q24(ITER);
    end else begin
      vec_d.x = vec_i.x + ys;
      vec_d.y = vec_i.y - xs;
      vec_d.z = vec_i.z + atan_q24(ITER);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      vec_q <= vec_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_q <= '0;
    end else if (en_i) begin
      side_q <= side_i;
    end
  end

  assign vec_o = vec_q;
  assign side_o = side_q;

endmodule

// ===== src/ggbs_atan2.sv =====
// Pipelined atan2 unit: sign fold, normalising shifts and a chain of CORDIC cells.
module ggbs_atan2 import ggbs_pkg::*; #(
  parameter int STEPS = 16,
  parameter int SW = 1
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic signed [VW-1:0] y_i,
  input  logic signed [VW-1:0] x_i,
  input  logic [SW-1:0]        side_i,
  output logic signed [15:0]   ang_o,
  output logic [SW-1:0]        side_o
);

  localparam int NS = 6;

  cordic_t pre_d;
  cordic_t norm_q [NS+1];
  logic [SW-1:0] nside_q [NS+1];
  cordic_t cell_v [STEPS+1];
  logic [SW-1:0] cell_s [STEPS+1];
  logic signed [ZW:0] zr;
  logic signed [17:0] r;
  logic signed [15:0] ang_d, ang_q;
  logic [SW-1:0] side_q;

  always_comb begin
    pre_d.zero = (x_i == '0) && (y_i == '0);
    if (x_i[VW-1]) begin
      pre_d.x = -x_i;
      pre_d.y = -y_i;
      pre_d.z = y_i[VW-1] ? -PI_Q24 : PI_Q24;
    end else begin
      pre_d.x = x_i;
      pre_d.y = y_i;
      pre_d.z = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      norm_q[0] <= pre_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nside_q[0] <= '0;
    end else if (en_i) begin
      nside_q[0] <= side_i;
    end
  end

  for (genvar k = 0; k < NS; k++) begin : g_norm
    localparam int SH = 32 >> k;
    logic [VW-1:0] ay, m;
    cordic_t nd;
    always_comb begin
      ay = norm_q[k].y[VW-1] ? VW'(-norm_q[k].y) : VW'(norm_q[k].y);
      m = (VW'(norm_q[k].x) > ay) ? VW'(norm_q[k].x) : ay;
      nd = norm_q[k];
      if (m[VW-1:33-SH] == '0) begin
        nd.x = norm_q[k].x <<< SH;
        nd.y = norm_q[k].y <<< SH;
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        norm_q[k+1] <= nd;
      end
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        nside_q[k+1] <= '0;
      end else if (en_i) begin
        nside_q[k+1] <= nside_q[k];
      end
    end
  end

  assign cell_v[0] = norm_q[NS];
  assign cell_s[0] = nside_q[NS];

  for (genvar i = 0; i < STEPS; i++) begin : g_cell
    ggbs_cordic_cell #(
      .ITER (i),
      .SW   (SW)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en_i),
      .vec_i  (cell_v[i]),
      .side_i (cell_s[i]),
      .vec_o  (cell_v[i+1]),
      .side_o (cell_s[i+1])
    );
  end

  always_comb begin
    zr = {cell_v[STEPS].z[ZW-1], cell_v[STEPS].z} + (ZW+1)'(1024);
    r = 18'(zr >>> 11);
    if (cell_v[STEPS].zero) begin
      ang_d = '0;
    end else if (r > 18'(PI_Q13)) begin
      ang_d = 16'(PI_Q13);
    end else if (r < -18'(PI_Q13)) begin
      ang_d = -16'(PI_Q13);
    end else begin
      ang_d = 16'(r);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ang_q <= ang_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_q <= '0;
    end else if (en_i) begin
      side_q <= cell_s[STEPS];
    end
  end

  assign ang_o = ang_q;
  assign side_o = side_q;

endmodule

// ===== src/go_to_goal_bang_bang_steering_top.sv =====
// Top level of the go-to-goal steering block: configuration, pose front end and decision.
// Throughput: one request per cycle; the whole pipeline, output register included,
// advances together and holds only while a waiting result is stalled.
// Reset clears the configuration to its defaults and empties the pipeline.
module go_to_goal_bang_bang_steering_top import ggbs_pkg::*; #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  pose_req_t   in_req_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output steer_rsp_t  out_rsp_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_wdata_i
);

  logic signed [31:0] goal_x_q, goal_y_q;
  logic [30:0] dist_db_q;
  logic [14:0] ang_db_q, fwd_speed_q, turn_speed_q;

  logic en;
  logic out_valid_q;
  steer_rsp_t rsp_d, rsp_q;

  logic v1_q, v2_q, v3_q;
  logic signed [32:0] dx1_q, dy1_q, dx2_q, dy2_q, dx3_q, dy3_q;
  logic signed [31:0] pzw_q, pxy_q, pww_q, pxx_q;
  logic [32:0] ax, ay;
  logic [61:0] ax2_q, ay2_q, dd2_q;
  logic far_q, arr3_q;
  logic signed [34:0] num_d, den_d, num2_q, den2_q, num3_q, den3_q;

  logic signed [15:0] bear, yaw;
  logic arr_o, vld_o;
  logic signed [16:0] e0, err;
  logic signed [16:0] adb;

  assign en = !(out_valid_q && out_stall_i);
  assign in_stall_o = !en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      goal_x_q <= '0;
      goal_y_q <= '0;
      dist_db_q <= DIST_DB_RST;
      ang_db_q <= ANG_DB_RST;
      fwd_speed_q <= FWD_SPEED_RST;
      turn_speed_q <= TURN_SPEED_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_GOAL_X: goal_x_q <= cfg_wdata_i;
        CFG_GOAL_Y: goal_y_q <= cfg_wdata_i;
        CFG_DIST_DB: dist_db_q <= cfg_wdata_i[30:0];
        CFG_ANG_DB: ang_db_q <= cfg_wdata_i[14:0];
        CFG_FWD_SPEED: fwd_speed_q <= cfg_wdata_i[14:0];
        CFG_TURN_SPEED: turn_speed_q <= cfg_wdata_i[14:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      out_valid_q <= vld_o;
    end
  end

  assign ax = dx1_q[32] ? 33'(-dx1_q) : 33'(dx1_q);
  assign ay = dy1_q[32] ? 33'(-dy1_q) : 33'(dy1_q);
  assign num_d = (35'(pzw_q) + 35'(pxy_q)) <<< 1;
  assign den_d = ((35'(pww_q) + 35'(pxx_q)) <<< 1) - 35'sd268435456;

  always_ff @(posedge clk_i) begin
    if (en) begin
      dx1_q <= {goal_x_q[31], goal_x_q} - {in_req_i.pose_x[31], in_req_i.pose_x};
      dy1_q <= {goal_y_q[31], goal_y_q} - {in_req_i.pose_y[31], in_req_i.pose_y};
      pzw_q <= in_req_i.quat_z * in_req_i.quat_w;
      pxy_q <= in_req_i.quat_x * in_req_i.quat_y;
      pww_q <= in_req_i.quat_w * in_req_i.quat_w;
      pxx_q <= in_req_i.quat_x * in_req_i.quat_x;

      dx2_q <= dx1_q;
      dy2_q <= dy1_q;
      num2_q <= num_d;
      den2_q <= den_d;
      far_q <= (ax[32:31] != 2'b00) || (ay[32:31] != 2'b00);
      ax2_q <= ax[30:0] * ax[30:0];
      ay2_q <= ay[30:0] * ay[30:0];
      dd2_q <= dist_db_q * dist_db_q;

      dx3_q <= dx2_q;
      dy3_q <= dy2_q;
      num3_q <= num2_q;
      den3_q <= den2_q;
      arr3_q <= !far_q && (({1'b0, ax2_q} + {1'b0, ay2_q}) < {1'b0, dd2_q});
    end
  end

  ggbs_atan2 #(
    .STEPS (CORDIC_STEPS),
    .SW    (1)
  ) u_bearing (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .y_i    (VW'(dy3_q)),
    .x_i    (VW'(dx3_q)),
    .side_i (arr3_q),
    .ang_o  (bear),
    .side_o (arr_o)
  );

  ggbs_atan2 #(
    .STEPS (CORDIC_STEPS),
    .SW    (1)
  ) u_yaw (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .y_i    (VW'(num3_q)),
    .x_i    (VW'(den3_q)),
    .side_i (v3_q),
    .ang_o  (yaw),
    .side_o (vld_o)
  );

  always_comb begin
    e0 = {bear[15], bear} - {yaw[15], yaw};
    if (e0 > PI_Q13) begin
      err = e0 - TWO_PI_Q13;
    end else if (e0 < -PI_Q13) begin
      err = e0 + TWO_PI_Q13;
    end else begin
      err = e0;
    end
    adb = {2'b00, ang_db_q};
    rsp_d.steer_err = 16'(err);
    rsp_d.linear_cmd = '0;
    rsp_d.angular_cmd = '0;
    if (arr_o) begin
      rsp_d.action = ACT_ARRIVED;
    end else if (err > adb) begin
      rsp_d.action = ACT_LEFT;
      rsp_d.angular_cmd = {1'b0, turn_speed_q};
    end else if (err < -adb) begin
      rsp_d.action = ACT_RIGHT;
      rsp_d.angular_cmd = -{1'b0, turn_speed_q};
    end else begin
      rsp_d.action = ACT_FORWARD;
      rsp_d.linear_cmd = fwd_speed_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      rsp_q <= rsp_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o = rsp_q;

endmodule
